@@ rtl/rth_pkg.sv @@
// Shared constants, codes and types of the ray/triangle hit test block.
package rth_pkg;

    localparam int FIELD_W         = 21;
    localparam int VERTEX_W        = 63;
    localparam int EPS_W           = 32;
    localparam int STATUS_W        = 3;
    localparam int DIST_W          = 32;
    localparam int NORMAL_W        = 45;
    localparam int CFG_INDEX_W     = 2;
    localparam int COORD_WIDTH_DEF = 21;
    localparam int T_FRAC_BITS_DEF = 16;
    localparam int MUL_CHUNK       = 24;
    localparam int TMUL_CHUNK      = 16;
    localparam int SETTLE_CYCLES   = 8;
    localparam int SETTLE_W        = $clog2(SETTLE_CYCLES + 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 3'd0,
        ST_PARALLEL = 3'd1,
        ST_BEHIND   = 3'd2,
        ST_OUTSIDE  = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_VERTEX_A = 2'd0,
        REG_VERTEX_B = 2'd1,
        REG_VERTEX_C = 2'd2,
        REG_EPSILON  = 2'd3
    } cfg_reg_t;

endpackage

@@ rtl/rth_if.sv @@
// Ray and hit channel interfaces of the ray/triangle hit test block.
interface rth_ray_if import rth_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] origin_x;
    logic signed [FIELD_W-1:0] origin_y;
    logic signed [FIELD_W-1:0] origin_z;
    logic signed [FIELD_W-1:0] dir_x;
    logic signed [FIELD_W-1:0] dir_y;
    logic signed [FIELD_W-1:0] dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

interface rth_hit_if import rth_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic [DIST_W-1:0]          distance;
    logic signed [NORMAL_W-1:0] normal_x;
    logic signed [NORMAL_W-1:0] normal_y;
    logic signed [NORMAL_W-1:0] normal_z;

    modport source (output valid, status, distance, normal_x, normal_y, normal_z,
                    input ready);
    modport sink   (input valid, status, distance, normal_x, normal_y, normal_z,
                    output ready);
endinterface

@@ rtl/rth_mul.sv @@
// Two-stage signed multiplier that splits the wide operand into chunks.
module rth_mul import rth_pkg::*; #(
    parameter int WA    = NORMAL_W,
    parameter int WB    = FIELD_W + 1,
    parameter int CHUNK = MUL_CHUNK
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);
    localparam int NC  = (WA + CHUNK - 1) / CHUNK;
    localparam int XW  = NC * CHUNK;
    localparam int PPW = CHUNK + 1 + WB;
    localparam int SW  = XW + WB + 1;

    logic signed [XW-1:0]    a_x;
    logic signed [PPW-1:0]   pp_reg [NC];
    logic signed [SW-1:0]    sum;
    logic signed [WA+WB-1:0] p_reg;

    assign a_x = XW'(a);

    // partial products: low chunks unsigned, top chunk carries the sign
    for (genvar j = 0; j < NC; j++)
    begin : g_pp
        logic signed [CHUNK:0] piece;
        if (j == NC - 1)
        begin : g_top
            assign piece = {a_x[XW-1], a_x[j*CHUNK +: CHUNK]};
        end
        else
        begin : g_low
            assign piece = {1'b0, a_x[j*CHUNK +: CHUNK]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pp_reg[j] <= piece * b;
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int j = 0; j < NC; j++)
        begin
            sum = sum + (SW'(pp_reg[j]) <<< (j * CHUNK));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= sum[WA+WB-1:0];
        end
    end

    assign p = p_reg;
endmodule

@@ rtl/ray_triangle_hit_test_top.sv @@
// Top level of the pipelined ray/triangle hit test.
//
// Tests one ray per clock against the triangle held in the vertex registers, using the
// plane-then-edges method in exact integer arithmetic. A ray accepted on the ray channel
// gives exactly one word on the hit channel. A new ray may enter every cycle unless the
// pipeline is frozen or a configuration write settles: one ray per clock otherwise. The
// restoring divider that forms t makes one quotient bit per stage (32 stages); six stages
// lie ahead of it (operand setup, split normal products, dot sums, sign and range checks)
// and six after it (edge vectors, split products, t times edge term).
// The normal and the per-edge vectors N x E are derived from the vertex registers by a
// free-running side pipeline, so after any configuration write the ray channel holds
// ready low until the settle counter runs out, while they settle. Status codes: 0 hit,
// 1 parallel (N.D zero or |N.D| below the epsilon), 2 behind the origin, 3 outside an edge
// (a point on an edge counts as inside), 4 t too large for the Q16.16 distance. Distance
// and normal are zero unless the status is hit. Each edge test uses the identity
// N.(E x (P - V)) = (P - V).(N x E), with P - V = 2^F (O - V) + t D.
module ray_triangle_hit_test_top import rth_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [VERTEX_W-1:0]    cfg_wdata,
    rth_ray_if.sink                ray,
    rth_hit_if.source              hit
);
    localparam int CE   = COORD_WIDTH + 1;        // edge / difference width
    localparam int NW   = 2 * COORD_WIDTH + 3;    // normal width
    localparam int MW   = 3 * COORD_WIDTH + 5;    // N x E width
    localparam int DW   = 3 * COORD_WIDTH + 5;    // N.D width
    localparam int NUMW = 3 * COORD_WIDTH + 6;    // N.(A-O) width
    localparam int AW   = 4 * COORD_WIDTH + 8;    // edge term width
    localparam int TW   = DIST_W;
    localparam int DVW  = DW + TW;
    localparam int CMPW = (NUMW + T_FRAC_BITS > DW + TW) ? NUMW + T_FRAC_BITS : DW + TW;
    localparam int PCW  = (DW > EPS_W) ? DW : EPS_W;
    localparam int XW   = AW + TW + 2;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [VERTEX_W-1:0] vtx_reg [3];
    logic [EPS_W-1:0]    eps_reg;
    logic [SETTLE_W-1:0] settle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_reg[0] <= '0;
            vtx_reg[1] <= '0;
            vtx_reg[2] <= '0;
            eps_reg    <= EPS_W'(1);
            settle_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_VERTEX_A: vtx_reg[0] <= cfg_wdata;
                REG_VERTEX_B: vtx_reg[1] <= cfg_wdata;
                REG_VERTEX_C: vtx_reg[2] <= cfg_wdata;
                REG_EPSILON:  eps_reg    <= cfg_wdata[EPS_W-1:0];
            endcase
            settle_reg <= SETTLE_W'(SETTLE_CYCLES);
        end
        else if (settle_reg != '0)
        begin
            settle_reg <= settle_reg - SETTLE_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // triangle side pipeline: edges, normal, N x E per edge (free running)
    // ------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] vc [3][3];
    logic signed [CE-1:0]          edge_reg [3][3];
    logic signed [2*CE-1:0]        nhi_reg [3];
    logic signed [2*CE-1:0]        nlo_reg [3];
    logic signed [NW-1:0]          norm_reg [3];
    logic signed [NW+CE-1:0]       mhi_w [3][3];
    logic signed [NW+CE-1:0]       mlo_w [3][3];
    logic signed [MW-1:0]          mvec_reg [3][3];

    // edge k runs from vertex k to the next one: AB, BC, CA
    for (genvar k = 0; k < 3; k++)
    begin : g_vtx
        localparam int KN = (k + 1) % 3;
        for (genvar i = 0; i < 3; i++)
        begin : g_crd
            assign vc[k][i] = vtx_reg[k][i*COORD_WIDTH +: COORD_WIDTH];
            always_ff @(posedge clk)
            begin
                edge_reg[k][i] <= CE'(vc[KN][i]) - CE'(vc[k][i]);
            end
        end
    end

    // N = (B - A) x (C - A) = CA x AB
    for (genvar i = 0; i < 3; i++)
    begin : g_norm
        localparam int I1 = (i + 1) % 3;
        localparam int I2 = (i + 2) % 3;
        always_ff @(posedge clk)
        begin
            nhi_reg[i]  <= edge_reg[2][I1] * edge_reg[0][I2];
            nlo_reg[i]  <= edge_reg[2][I2] * edge_reg[0][I1];
            norm_reg[i] <= NW'(nhi_reg[i]) - NW'(nlo_reg[i]);
        end
    end

    // M_k = N x E_k, the inward test vector of each edge
    for (genvar k = 0; k < 3; k++)
    begin : g_mvec
        for (genvar i = 0; i < 3; i++)
        begin : g_axis
            localparam int I1 = (i + 1) % 3;
            localparam int I2 = (i + 2) % 3;
            rth_mul #(.WA(NW), .WB(CE), .CHUNK(MUL_CHUNK)) u_mhi (
                .clk (clk), .en (1'b1),
                .a   (norm_reg[I1]), .b (edge_reg[k][I2]), .p (mhi_w[k][i])
            );
            rth_mul #(.WA(NW), .WB(CE), .CHUNK(MUL_CHUNK)) u_mlo (
                .clk (clk), .en (1'b1),
                .a   (norm_reg[I2]), .b (edge_reg[k][I1]), .p (mlo_w[k][i])
            );
            always_ff @(posedge clk)
            begin
                mvec_reg[k][i] <= MW'(mhi_w[k][i]) - MW'(mlo_w[k][i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // flow control: the whole ray pipeline moves together; it freezes only
    // when a finished word waits in the output register and another is behind it
    // ------------------------------------------------------------------
    logic adv;
    logic r6_valid_reg;
    logic out_valid_reg;

    assign adv       = !(r6_valid_reg && out_valid_reg && !hit.ready);
    assign ray.ready = adv && (settle_reg == '0);

    // ------------------------------------------------------------------
    // stages p1..p5: operands, N.D and N.(A - O)
    // ------------------------------------------------------------------
    logic                          p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic                          p4_valid_reg, p5_valid_reg;
    logic signed [COORD_WIDTH-1:0] p1_o_reg [3], p1_d_reg [3];
    logic signed [COORD_WIDTH-1:0] p2_o_reg [3], p2_d_reg [3];
    logic signed [COORD_WIDTH-1:0] p3_o_reg [3], p3_d_reg [3];
    logic signed [COORD_WIDTH-1:0] p4_o_reg [3], p4_d_reg [3];
    logic signed [COORD_WIDTH-1:0] p5_o_reg [3], p5_d_reg [3];
    logic signed [CE-1:0]          p2_ao_reg [3];
    logic signed [NW+COORD_WIDTH-1:0] dterm_w [3];
    logic signed [NW+CE-1:0]       nterm_w [3];
    logic signed [DW-1:0]          den_reg;
    logic signed [NUMW-1:0]        num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= ray.valid && (settle_reg == '0);
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_o_reg[0] <= ray.origin_x[COORD_WIDTH-1:0];
            p1_o_reg[1] <= ray.origin_y[COORD_WIDTH-1:0];
            p1_o_reg[2] <= ray.origin_z[COORD_WIDTH-1:0];
            p1_d_reg[0] <= ray.dir_x[COORD_WIDTH-1:0];
            p1_d_reg[1] <= ray.dir_y[COORD_WIDTH-1:0];
            p1_d_reg[2] <= ray.dir_z[COORD_WIDTH-1:0];
            p2_o_reg    <= p1_o_reg;
            p2_d_reg    <= p1_d_reg;
            p3_o_reg    <= p2_o_reg;
            p3_d_reg    <= p2_d_reg;
            p4_o_reg    <= p3_o_reg;
            p4_d_reg    <= p3_d_reg;
            p5_o_reg    <= p4_o_reg;
            p5_d_reg    <= p4_d_reg;
            den_reg     <= DW'(dterm_w[0]) + DW'(dterm_w[1]) + DW'(dterm_w[2]);
            num_reg     <= NUMW'(nterm_w[0]) + NUMW'(nterm_w[1]) + NUMW'(nterm_w[2]);
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_dot
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                p2_ao_reg[i] <= CE'(vc[0][i]) - CE'(p1_o_reg[i]);
            end
        end
        rth_mul #(.WA(NW), .WB(COORD_WIDTH), .CHUNK(MUL_CHUNK)) u_den (
            .clk (clk), .en (adv),
            .a   (norm_reg[i]), .b (p2_d_reg[i]), .p (dterm_w[i])
        );
        rth_mul #(.WA(NW), .WB(CE), .CHUNK(MUL_CHUNK)) u_num (
            .clk (clk), .en (adv),
            .a   (norm_reg[i]), .b (p2_ao_reg[i]), .p (nterm_w[i])
        );
    end

    // ------------------------------------------------------------------
    // stage p6: parallel, behind and range checks; divider setup
    // ------------------------------------------------------------------
    logic [DW-1:0]   aden_next;
    logic [NUMW-1:0] anum_next;
    logic [CMPW-1:0] rem_wide;
    status_t         status_next;

    logic                          dv_valid_reg  [TW+1];
    status_t                       dv_status_reg [TW+1];
    logic [DVW-1:0]                dv_rem_reg    [TW+1];
    logic [DW-1:0]                 dv_aden_reg   [TW+1];
    logic [TW-1:0]                 dv_t_reg      [TW+1];
    logic signed [COORD_WIDTH-1:0] dv_o_reg      [TW+1][3];
    logic signed [COORD_WIDTH-1:0] dv_d_reg      [TW+1][3];

    always_comb
    begin
        aden_next = den_reg[DW-1] ? DW'(-den_reg) : DW'(den_reg);
        anum_next = num_reg[NUMW-1] ? NUMW'(-num_reg) : NUMW'(num_reg);
        rem_wide  = CMPW'(anum_next) << T_FRAC_BITS;
        priority if ((den_reg == '0) || (PCW'(aden_next) < PCW'(eps_reg)))
            status_next = ST_PARALLEL;
        else if ((num_reg != '0) && (num_reg[NUMW-1] != den_reg[DW-1]))
            status_next = ST_BEHIND;
        else if (rem_wide >= (CMPW'(aden_next) << TW))
            status_next = ST_RANGE;
        else
            status_next = ST_HIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_valid_reg[0] <= p5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_status_reg[0] <= status_next;
            dv_rem_reg[0]    <= rem_wide[DVW-1:0];
            dv_aden_reg[0]   <= aden_next;
            dv_t_reg[0]      <= '0;
            dv_o_reg[0]      <= p5_o_reg;
            dv_d_reg[0]      <= p5_d_reg;
        end
    end

    // ------------------------------------------------------------------
    // restoring divider: one quotient bit per stage, most significant first
    // ------------------------------------------------------------------
    for (genvar j = 0; j < TW; j++)
    begin : g_div
        localparam int QB = TW - 1 - j;
        logic [DVW-1:0] shifted;
        logic           take;

        assign shifted = DVW'(dv_aden_reg[j]) << QB;
        assign take    = dv_rem_reg[j] >= shifted;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_status_reg[j+1] <= dv_status_reg[j];
                dv_rem_reg[j+1]    <= take ? dv_rem_reg[j] - shifted : dv_rem_reg[j];
                dv_aden_reg[j+1]   <= dv_aden_reg[j];
                dv_t_reg[j+1]      <= dv_t_reg[j] | (TW'(take) << QB);
                dv_o_reg[j+1]      <= dv_o_reg[j];
                dv_d_reg[j+1]      <= dv_d_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // stages r1..r6: edge terms A_k = (O - V_k).M_k, B_k = D.M_k, then t * B_k
    // ------------------------------------------------------------------
    logic                  r1_valid_reg, r2_valid_reg, r3_valid_reg;
    logic                  r4_valid_reg, r5_valid_reg;
    status_t               r1_status_reg, r2_status_reg, r3_status_reg;
    status_t               r4_status_reg, r5_status_reg, r6_status_reg;
    logic [TW-1:0]         r1_t_reg, r2_t_reg, r3_t_reg, r4_t_reg, r5_t_reg, r6_t_reg;
    logic signed [CE-1:0]  r1_ovk_reg [3][3];
    logic signed [COORD_WIDTH-1:0] r1_d_reg [3];
    logic signed [MW+CE-1:0]          aterm_w [3][3];
    logic signed [MW+COORD_WIDTH-1:0] bterm_w [3][3];
    logic signed [AW-1:0]  r4_a_reg [3], r4_b_reg [3];
    logic signed [AW-1:0]  r5_a_reg [3], r6_a_reg [3];
    logic signed [TW:0]    r4_ts;
    logic signed [AW+TW:0] tb_w [3];

    assign r4_ts = {1'b0, r4_t_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            r3_valid_reg <= 1'b0;
            r4_valid_reg <= 1'b0;
            r5_valid_reg <= 1'b0;
            r6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r1_valid_reg <= dv_valid_reg[TW];
            r2_valid_reg <= r1_valid_reg;
            r3_valid_reg <= r2_valid_reg;
            r4_valid_reg <= r3_valid_reg;
            r5_valid_reg <= r4_valid_reg;
            r6_valid_reg <= r5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_status_reg <= dv_status_reg[TW];
            r2_status_reg <= r1_status_reg;
            r3_status_reg <= r2_status_reg;
            r4_status_reg <= r3_status_reg;
            r5_status_reg <= r4_status_reg;
            r6_status_reg <= r5_status_reg;
            r1_t_reg      <= dv_t_reg[TW];
            r2_t_reg      <= r1_t_reg;
            r3_t_reg      <= r2_t_reg;
            r4_t_reg      <= r3_t_reg;
            r5_t_reg      <= r4_t_reg;
            r6_t_reg      <= r5_t_reg;
            r1_d_reg      <= dv_d_reg[TW];
            r5_a_reg      <= r4_a_reg;
            r6_a_reg      <= r5_a_reg;
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_edge
        for (genvar i = 0; i < 3; i++)
        begin : g_axis
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    r1_ovk_reg[k][i] <= CE'(dv_o_reg[TW][i]) - CE'(vc[k][i]);
                end
            end
            rth_mul #(.WA(MW), .WB(CE), .CHUNK(MUL_CHUNK)) u_aterm (
                .clk (clk), .en (adv),
                .a   (mvec_reg[k][i]), .b (r1_ovk_reg[k][i]), .p (aterm_w[k][i])
            );
            rth_mul #(.WA(MW), .WB(COORD_WIDTH), .CHUNK(MUL_CHUNK)) u_bterm (
                .clk (clk), .en (adv),
                .a   (mvec_reg[k][i]), .b (r1_d_reg[i]), .p (bterm_w[k][i])
            );
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r4_a_reg[k] <= AW'(aterm_w[k][0]) + AW'(aterm_w[k][1]) + AW'(aterm_w[k][2]);
                r4_b_reg[k] <= AW'(bterm_w[k][0]) + AW'(bterm_w[k][1]) + AW'(bterm_w[k][2]);
            end
        end

        rth_mul #(.WA(AW), .WB(TW + 1), .CHUNK(TMUL_CHUNK)) u_tterm (
            .clk (clk), .en (adv),
            .a   (r4_b_reg[k]), .b (r4_ts), .p (tb_w[k])
        );
    end

    // ------------------------------------------------------------------
    // final edge signs and output register
    // ------------------------------------------------------------------
    logic signed [XW-1:0] edge_val [3];
    logic                 outside;
    status_t              out_status_next;
    status_t              out_status_reg;
    logic [TW-1:0]        out_dist_reg;
    logic signed [NORMAL_W-1:0] out_norm_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            edge_val[k] = (XW'(r6_a_reg[k]) <<< T_FRAC_BITS) + XW'(tb_w[k]);
        end
        outside = edge_val[0][XW-1] || edge_val[1][XW-1] || edge_val[2][XW-1];
        if ((r6_status_reg == ST_HIT) && outside)
            out_status_next = ST_OUTSIDE;
        else
            out_status_next = r6_status_reg;
    end

    // hold a word that waits; otherwise take what the last stage offers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || hit.ready)
        begin
            out_valid_reg <= r6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || hit.ready)
        begin
            out_status_reg <= out_status_next;
            if (out_status_next == ST_HIT)
            begin
                out_dist_reg    <= r6_t_reg;
                out_norm_reg[0] <= NORMAL_W'(norm_reg[0]);
                out_norm_reg[1] <= NORMAL_W'(norm_reg[1]);
                out_norm_reg[2] <= NORMAL_W'(norm_reg[2]);
            end
            else
            begin
                out_dist_reg    <= '0;
                out_norm_reg[0] <= '0;
                out_norm_reg[1] <= '0;
                out_norm_reg[2] <= '0;
            end
        end
    end

    assign hit.valid    = out_valid_reg;
    assign hit.status   = out_status_reg;
    assign hit.distance = out_dist_reg;
    assign hit.normal_x = out_norm_reg[0];
    assign hit.normal_y = out_norm_reg[1];
    assign hit.normal_z = out_norm_reg[2];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a configuration write must hold off rays while derived terms settle
    a_cfg_holds_rays: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !ray.ready)
        else $error("ray accepted right after a configuration write");

    // a waiting word with another one behind it must freeze the input
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (hit.valid && !hit.ready && r6_valid_reg) |-> !ray.ready)
        else $error("ray accepted while the pipeline is frozen");

    // a miss carries no distance and no normal
    a_miss_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (hit.valid && (hit.status != ST_HIT)) |->
        ((hit.distance == '0) && (hit.normal_x == '0) && (hit.normal_y == '0)
         && (hit.normal_z == '0)))
        else $error("non-hit word carries payload");
endmodule

@@ bench/tb.sv @@
// Self-checking testbench of the ray/triangle hit test block.
module tb import rth_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] ox;
        logic signed [FIELD_W-1:0] oy;
        logic signed [FIELD_W-1:0] oz;
        logic signed [FIELD_W-1:0] dx;
        logic signed [FIELD_W-1:0] dy;
        logic signed [FIELD_W-1:0] dz;
    } ray_t;

    typedef struct packed {
        status_t                    status;
        logic [DIST_W-1:0]          distance;
        logic signed [NORMAL_W-1:0] nx;
        logic signed [NORMAL_W-1:0] ny;
        logic signed [NORMAL_W-1:0] nz;
    } hit_word_t;

    localparam int FRAC       = T_FRAC_BITS_DEF;
    localparam int DRAIN_WAIT = 60;    // pipeline latency plus margin
    localparam int IDLE_LIMIT = 20000; // cycles without any handshake
    localparam int HOLD_LEN   = 300;   // long receiver hold-off

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [VERTEX_W-1:0]    cfg_wdata;

    rth_ray_if ray ();
    rth_hit_if hit ();

    ray_triangle_hit_test_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ray       (ray),
        .hit       (hit)
    );

    // Shadow copy of the triangle and the parallel threshold.
    logic [VERTEX_W-1:0] tri_vtx [3];
    logic [EPS_W-1:0]    eps_reg;

    hit_word_t pending_hits [$];
    int        errors;
    int        idle_cycles;
    int        ready_pct;
    int        gap_max;
    bit        hold_req;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic wide_t coord(logic [VERTEX_W-1:0] v, int axis);
        logic signed [FIELD_W-1:0] c;
        c = v[axis*FIELD_W +: FIELD_W];
        return wide_t'(c);
    endfunction

    function automatic logic [VERTEX_W-1:0] pack_vtx(longint x, longint y, longint z);
        logic [FIELD_W-1:0] px, py, pz;
        px = x[FIELD_W-1:0];
        py = y[FIELD_W-1:0];
        pz = z[FIELD_W-1:0];
        return {pz, py, px};
    endfunction

    // Plane intersection, quantized t, then a side test on each edge.
    function automatic hit_word_t predict_hit(ray_t r);
        wide_t     v [3][3];
        wide_t     o [3];
        wide_t     d [3];
        wide_t     n [3];
        wide_t     e1 [3];
        wide_t     e2 [3];
        wide_t     p [3];
        wide_t     e [3];
        wide_t     vp [3];
        wide_t     den, num, aden, anum, rem, tw, side;
        wide_t     eps_w;
        logic [DIST_W-1:0] t;
        hit_word_t res;
        int        nx;
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
                v[k][i] = coord(tri_vtx[k], i);
        o[0] = wide_t'(r.ox); o[1] = wide_t'(r.oy); o[2] = wide_t'(r.oz);
        d[0] = wide_t'(r.dx); d[1] = wide_t'(r.dy); d[2] = wide_t'(r.dz);
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = v[1][i] - v[0][i];
            e2[i] = v[2][i] - v[0][i];
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        den = 0;
        num = 0;
        for (int i = 0; i < 3; i++)
        begin
            den = den + n[i] * d[i];
            num = num + n[i] * (v[0][i] - o[i]);
        end
        aden  = (den < 0) ? -den : den;
        anum  = (num < 0) ? -num : num;
        eps_w = 0;
        eps_w[EPS_W-1:0] = eps_reg;
        t = '0;
        res.status = ST_HIT;
        if (den == 0 || aden < eps_w)
            res.status = ST_PARALLEL;
        else if (num != 0 && ((num < 0) != (den < 0)))
            res.status = ST_BEHIND;
        else
        begin
            rem = anum <<< FRAC;
            if (rem >= (aden <<< 32))
                res.status = ST_RANGE;
            else
            begin
                tw = rem / aden;
                t  = tw[DIST_W-1:0];
                for (int i = 0; i < 3; i++)
                    p[i] = (o[i] <<< FRAC) + tw * d[i];
                for (int k = 0; k < 3; k++)
                begin
                    nx = (k + 1) % 3;
                    for (int i = 0; i < 3; i++)
                    begin
                        e[i]  = v[nx][i] - v[k][i];
                        vp[i] = p[i] - (v[k][i] <<< FRAC);
                    end
                    side = n[0] * (e[1] * vp[2] - e[2] * vp[1])
                         + n[1] * (e[2] * vp[0] - e[0] * vp[2])
                         + n[2] * (e[0] * vp[1] - e[1] * vp[0]);
                    if (side < 0)
                        res.status = ST_OUTSIDE;
                end
            end
        end
        if (res.status == ST_HIT)
        begin
            res.distance = t;
            res.nx = n[0][NORMAL_W-1:0];
            res.ny = n[1][NORMAL_W-1:0];
            res.nz = n[2][NORMAL_W-1:0];
        end
        else
        begin
            res.distance = '0;
            res.nx = '0;
            res.ny = '0;
            res.nz = '0;
        end
        return res;
    endfunction

    // Offer one ray and hold it until the block takes it; valid stays high.
    task automatic send_ray(ray_t r);
        ray.valid    <= 1'b1;
        ray.origin_x <= r.ox;
        ray.origin_y <= r.oy;
        ray.origin_z <= r.oz;
        ray.dir_x    <= r.dx;
        ray.dir_y    <= r.dy;
        ray.dir_z    <= r.dz;
        do
            @(posedge clk);
        while (!ray.ready);
        pending_hits.push_back(predict_hit(r));
    endtask

    task automatic pause_sender(int cycles);
        ray.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Hold off until every expected word is back and the pipe is empty.
    task automatic drain_block();
        ray.valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Drive one register write; the caller drops the write enable afterwards.
    task automatic write_reg(cfg_reg_t idx, logic [VERTEX_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        if (idx == REG_EPSILON)
            eps_reg = value[EPS_W-1:0];
        else
            tri_vtx[idx] = value;
    endtask

    task automatic set_triangle(logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b,
                                logic [VERTEX_W-1:0] c, logic [EPS_W-1:0] eps);
        drain_block();
        write_reg(REG_VERTEX_A, a);
        write_reg(REG_VERTEX_B, b);
        write_reg(REG_VERTEX_C, c);
        write_reg(REG_EPSILON, {31'b0, eps});
        cfg_we <= 1'b0;
    endtask

    function automatic ray_t make_ray(longint ox, longint oy, longint oz,
                                      longint dx, longint dy, longint dz);
        ray_t r;
        r.ox = ox[FIELD_W-1:0]; r.oy = oy[FIELD_W-1:0]; r.oz = oz[FIELD_W-1:0];
        r.dx = dx[FIELD_W-1:0]; r.dy = dy[FIELD_W-1:0]; r.dz = dz[FIELD_W-1:0];
        return r;
    endfunction

    function automatic ray_t noise_ray();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return bits[$bits(ray_t)-1:0];
    endfunction

    // Aim at a point inside the triangle from a nearby origin; the shift on
    // the direction spreads t over several octaves.
    function automatic ray_t aimed_ray();
        longint pt [3];
        longint org [3];
        longint dir [3];
        longint a, b, c;
        int     u, w, sh, span;
        u    = $urandom_range(0, 256);
        w    = $urandom_range(0, 256 - u);
        sh   = $urandom_range(0, 4);
        span = 1 << $urandom_range(2, 17);
        for (int i = 0; i < 3; i++)
        begin
            a = longint'(coord(tri_vtx[0], i));
            b = longint'(coord(tri_vtx[1], i));
            c = longint'(coord(tri_vtx[2], i));
            pt[i]  = a + (u * (b - a) + w * (c - a)) / 256;
            org[i] = pt[i] + longint'($urandom_range(0, 2 * span)) - span;
            dir[i] = (pt[i] - org[i]) >>> sh;
            if ($urandom_range(0, 9) == 0)
                dir[i] = -dir[i];
        end
        return make_ray(org[0], org[1], org[2], dir[0], dir[1], dir[2]);
    endfunction

    // Bursts of random length with random gaps when gap_max is above zero; aimed_pct percent aimed.
    task automatic random_rays(int count, int aimed_pct);
        int burst;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && sent < count; j++)
            begin
                if ($urandom_range(0, 99) < aimed_pct)
                    send_ray(aimed_ray());
                else
                    send_ray(noise_ray());
                sent++;
            end
            if (gap_max > 0 && $urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, gap_max));
        end
    endtask

    function automatic logic [VERTEX_W-1:0] rand_vtx(int mag);
        return pack_vtx(longint'($urandom_range(0, 2 * mag)) - mag,
                        longint'($urandom_range(0, 2 * mag)) - mag,
                        longint'($urandom_range(0, 2 * mag)) - mag);
    endfunction

    // Reset state: all vertices zero, so every ray is parallel.
    task automatic test_reset_defaults();
        send_ray(make_ray(0, 0, 0, 0, 0, 0));
        send_ray(make_ray(1048575, -1048576, 1048575, -1048576, 1048575, -1048576));
        random_rays(40, 0);
    endtask

    // Axis-aligned triangle in z = 0 with N = (0, 0, 2^24).
    task automatic test_directed_cases();
        set_triangle(pack_vtx(0, 0, 0), pack_vtx(4096, 0, 0), pack_vtx(0, 4096, 0), 1);
        send_ray(make_ray(100, 100, 1000, 0, 0, -1));          // plain hit, t = 1000
        send_ray(make_ray(100, 100, 1000, 0, 0, 1));           // behind the origin
        send_ray(make_ray(100, 100, 1000, 1, 0, 0));           // parallel, N.D = 0
        send_ray(make_ray(100, 100, 0, 0, 0, -1));             // origin in plane, t = 0
        send_ray(make_ray(5000, 5000, 1000, 0, 0, -1));        // outside an edge
        send_ray(make_ray(0, 0, 100000, 0, 0, -1));            // t too large
        send_ray(make_ray(0, 0, 65535, 0, 0, -1));             // largest t in range
        send_ray(make_ray(2048, 0, 50, 0, 0, -1));             // on edge AB
        send_ray(make_ray(2048, 2048, 50, 0, 0, -1));          // on edge BC
        send_ray(make_ray(0, 0, 7, 0, 0, -3));                 // fractional t, on a vertex
        send_ray(make_ray(1000, 1000, 1048575, 3, -2, -1048576));
        send_ray(make_ray(-1048576, -1048576, -1048576, 1048575, 1048575, 1048575));
        send_ray(make_ray(1048575, 1048575, 1048575, -1048576, -1048576, -1048576));
        // Epsilon at its maximum: everything small is parallel.
        set_triangle(tri_vtx[0], tri_vtx[1], tri_vtx[2], 32'hFFFF_FFFF);
        send_ray(make_ray(100, 100, 1000, 0, 0, -1));
        send_ray(make_ray(100, 100, 1000, 0, 0, -1048576));
        // Epsilon zero: only an exact zero denominator is parallel.
        set_triangle(tri_vtx[0], tri_vtx[1], tri_vtx[2], 0);
        send_ray(make_ray(100, 100, 1000, 1, 0, 0));
        send_ray(make_ray(100, 100, 1000, 0, 0, -1));
        // Degenerate triangle: collinear vertices give N = 0.
        set_triangle(pack_vtx(0, 0, 0), pack_vtx(10, 10, 10), pack_vtx(20, 20, 20), 0);
        send_ray(make_ray(5, 5, 100, 0, 0, -1));
    endtask

    task automatic test_small_triangles();
        for (int ph = 0; ph < 4; ph++)
        begin
            set_triangle(rand_vtx(1 << 17), rand_vtx(1 << 17), rand_vtx(1 << 17),
                         $urandom_range(0, 1 << (4 * ph)));
            random_rays(200, 80);
        end
    endtask

    // Vertices at the coordinate extremes stretch N to its full width.
    task automatic test_extreme_vertices();
        set_triangle(pack_vtx(-1048576, -1048576, -1048576),
                     pack_vtx(1048575, -1048576, 1048575),
                     pack_vtx(-1048576, 1048575, 1048575), $urandom);
        random_rays(150, 70);
        set_triangle({VERTEX_W{1'b1}}, rand_vtx(1 << 20), {1'b0, {(VERTEX_W-1){1'b1}}},
                     $urandom_range(0, 255));
        random_rays(150, 70);
    endtask

    // Receiver holds off for a long stretch while rays keep coming, then
    // the sender waits for every word before the stream resumes.
    task automatic test_backpressure();
        set_triangle(rand_vtx(1 << 16), rand_vtx(1 << 16), rand_vtx(1 << 16), 1);
        gap_max  = 0;
        hold_req = 1'b1;
        random_rays(150, 80);
        drain_block();
        gap_max = 6;
        random_rays(150, 80);
    endtask

    task automatic test_wide_noise();
        set_triangle(rand_vtx(1 << 20), rand_vtx(1 << 20), rand_vtx(1 << 20), $urandom);
        random_rays(200, 50);
    endtask

    // Receiver: stall rate changes at the end of each random span, including
    // stretches with no stall at all; a hold-off request takes priority.
    always @(posedge clk or negedge rst_n)
    begin
        int hold_left;
        int span_left;
        if (!rst_n)
        begin
            hit.ready <= 1'b0;
            hold_left = 0;
            span_left = 0;
            ready_pct = 100;
        end
        else
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (span_left == 0)
            begin
                span_left = $urandom_range(50, 300);
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 40;
                    default: ready_pct = 10;
                endcase
            end
            span_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                hit.ready <= 1'b0;
            end
            else
                hit.ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // Compare every accepted hit word with the oldest prediction.
    always @(posedge clk)
    begin
        hit_word_t want;
        if (rst_n && hit.valid && hit.ready)
        begin
            if (pending_hits.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected hit word, status %0d", $time, hit.status);
            end
            else
            begin
                want = pending_hits.pop_front();
                if (hit.status !== want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, hit.status);
                end
                if (hit.distance !== want.distance)
                begin
                    errors++;
                    $display("%0t: distance expected %h actual %h",
                             $time, want.distance, hit.distance);
                end
                if (hit.normal_x !== want.nx || hit.normal_y !== want.ny ||
                    hit.normal_z !== want.nz)
                begin
                    errors++;
                    $display("%0t: normal expected %0d %0d %0d actual %0d %0d %0d",
                             $time, want.nx, want.ny, want.nz,
                             hit.normal_x, hit.normal_y, hit.normal_z);
                end
            end
        end
    end

    // Watchdog: end the run when no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((ray.valid && ray.ready) || (hit.valid && hit.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("ray_triangle_hit_test_top verification failed");
            $finish;
        end
    end

    initial
    begin
        errors       = 0;
        idle_cycles  = 0;
        hold_req     = 1'b0;
        gap_max      = 5;
        ready_pct    = 100;
        tri_vtx[0]   = '0;
        tri_vtx[1]   = '0;
        tri_vtx[2]   = '0;
        eps_reg      = 1;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_VERTEX_A;
        cfg_wdata    = '0;
        ray.valid    = 1'b0;
        ray.origin_x = '0;
        ray.origin_y = '0;
        ray.origin_z = '0;
        ray.dir_x    = '0;
        ray.dir_y    = '0;
        ray.dir_z    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_directed_cases();
        test_small_triangles();
        test_extreme_vertices();
        test_backpressure();
        test_wide_noise();

        drain_block();
        if (errors == 0)
            $display("ray_triangle_hit_test_top verification clean");
        else
            $display("ray_triangle_hit_test_top verification failed");
        $finish;
    end

endmodule
